FILE: hw/rtl/keypad_multitap_text_entry_macros.svh
// assertion macros used by the checker file
`ifndef KEYPAD_MULTITAP_TEXT_ENTRY_MACROS_SVH
`define KEYPAD_MULTITAP_TEXT_ENTRY_MACROS_SVH

// same-cycle implication, clocked on clk, disabled during reset
`define KMTE_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("keypad checker: same-cycle property failed");

// next-cycle implication, clocked on clk, disabled during reset
`define KMTE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("keypad checker: next-cycle property failed");

`endif

FILE: hw/rtl/kmte_pkg.sv
package kmte_pkg;

	localparam int SCAN_W = 9;
	localparam logic [3:0] NO_BUTTON = 4'd15;
	localparam logic [6:0] DIGIT_ONE = 7'h31;

	// chord buttons, zero based
	localparam int CLR_A = 1;
	localparam int CLR_B = 2;
	localparam int TOG_A = 4;
	localparam int TOG_B = 5;
	localparam int STO_A = 7;
	localparam int STO_B = 8;

	typedef struct packed {
		logic       letter_mode;
		logic [3:0] last_button;
		logic [1:0] tap_index;
	} tap_state_t;

	typedef struct packed {
		logic [6:0] char_code;
		logic [4:0] position;
		logic       replaced;
		logic       dropped;
	} char_result_t;

	function automatic logic [6:0] letter_char(input logic [3:0] idx, input logic [1:0] tap);
		logic [6:0] c0, c1, c2;
		begin
			case (idx)
				4'd0: begin c0 = 7'h2E; c1 = 7'h51; c2 = 7'h5A; end // . Q Z
				4'd1: begin c0 = 7'h41; c1 = 7'h42; c2 = 7'h43; end // A B C
				4'd2: begin c0 = 7'h44; c1 = 7'h45; c2 = 7'h46; end // D E F
				4'd3: begin c0 = 7'h47; c1 = 7'h48; c2 = 7'h49; end // G H I
				4'd4: begin c0 = 7'h4A; c1 = 7'h4B; c2 = 7'h4C; end // J K L
				4'd5: begin c0 = 7'h4D; c1 = 7'h4E; c2 = 7'h4F; end // M N O
				4'd6: begin c0 = 7'h50; c1 = 7'h52; c2 = 7'h53; end // P R S
				4'd7: begin c0 = 7'h54; c1 = 7'h55; c2 = 7'h56; end // T U V
				4'd8: begin c0 = 7'h57; c1 = 7'h58; c2 = 7'h59; end // W X Y
				default: begin c0 = 7'h2E; c1 = 7'h2E; c2 = 7'h2E; end
			endcase
			case (tap)
				2'd1: letter_char = c1;
				2'd2: letter_char = c2;
				default: letter_char = c0;
			endcase
		end
	endfunction

endpackage

FILE: hw/rtl/keypad_multitap_text_entry.sv
// Multi-tap keypad text entry. Each scan transfer carries the pressed flags of the
// push buttons; buttons 2+3 clear the text, 8+9 are swallowed, 5+6 flip between
// number and letter mode (such a scan types nothing), and every other pressed
// button types one character in ascending order (a repeated letter key cycles
// its letter in place). The typing stage passes on one character per cycle
// while the output register is free; at most one button of each chord pair can
// still type, so a scan types up to six characters. The next scan is taken in the
// cycle its predecessor's last character moves to the output register. The output
// register lets the typing stage run ahead by one character while the sink stalls.
module keypad_multitap_text_entry #(
	parameter int NUM_BUTTONS   = 9,
	parameter int TEXT_CAPACITY = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       scan_valid,
	output logic       scan_stall,
	input  logic [8:0] buttons,
	output logic       char_valid,
	input  logic       char_stall,
	output logic [6:0] char_code,
	output logic [4:0] position,
	output logic       replaced,
	output logic       dropped,
	output logic       last_of_scan
);
	import kmte_pkg::*;

	localparam int LEN_W = $clog2(TEXT_CAPACITY + 1);

	// typing stage: buttons still to type plus pending chord effects
	logic              valid_s1;
	logic [SCAN_W-1:0] rem_s1;
	logic              clr_s1;
	logic              tog_s1;

	// editor state
	tap_state_t        st_q;
	logic [LEN_W-1:0]  len_q;

	// output register
	logic              out_valid_q;
	char_result_t      out_q;
	logic              out_last_q;

	logic [SCAN_W-1:0] scan_mask;
	logic [SCAN_W-1:0] masked;
	logic [SCAN_W-1:0] after_clr;
	logic [SCAN_W-1:0] after_sto;
	logic              chord_clr;
	logic              chord_sto;
	logic              chord_tog;

	logic [SCAN_W-1:0] rem_next;
	logic              has_bits;
	logic              out_free;
	logic              step;
	logic              finishing;
	logic              take;
	logic              emit;

	char_result_t      res;
	tap_state_t        st_n;
	tap_state_t        st_upd;
	logic [LEN_W-1:0]  len_n;

	// buttons at or above NUM_BUTTONS do not exist
	always_comb begin
		for (int i = 0; i < SCAN_W; i++) begin
			scan_mask[i] = (i < NUM_BUTTONS);
		end
	end

	// chord decode on the incoming scan, in priority order
	assign masked    = buttons & scan_mask;
	assign chord_clr = masked[CLR_A] & masked[CLR_B];
	assign after_clr = chord_clr ? (masked & ~(SCAN_W'(1) << CLR_A) & ~(SCAN_W'(1) << CLR_B))
	                             : masked;
	assign chord_sto = after_clr[STO_A] & after_clr[STO_B];
	assign after_sto = chord_sto ? (after_clr & ~(SCAN_W'(1) << STO_A) & ~(SCAN_W'(1) << STO_B))
	                             : after_clr;
	assign chord_tog = after_sto[TOG_A] & after_sto[TOG_B];

	// handshake: a character may leave the stage when the output register frees up
	assign has_bits   = |rem_s1;
	assign rem_next   = rem_s1 & (rem_s1 - SCAN_W'(1));
	assign out_free   = !out_valid_q || !char_stall;
	assign step       = valid_s1 && (!has_bits || out_free);
	assign finishing  = step && (rem_next == '0);
	assign scan_stall = valid_s1 && !finishing;
	assign take       = scan_valid && !scan_stall;
	assign emit       = step && has_bits;

	kmte_tap_logic #(
		.TEXT_CAPACITY(TEXT_CAPACITY)
	) u_tap (
		.rem  (rem_s1),
		.clr  (clr_s1),
		.st   (st_q),
		.len  (len_q),
		.res  (res),
		.st_n (st_n),
		.len_n(len_n)
	);

	// toggle chord flips the mode on top of the editor update
	always_comb begin
		st_upd = st_n;
		st_upd.letter_mode = st_n.letter_mode ^ tog_s1;
	end

	// typing stage and editor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rem_s1   <= '0;
			clr_s1   <= 1'b0;
			tog_s1   <= 1'b0;
			st_q     <= '{letter_mode: 1'b0, last_button: NO_BUTTON, tap_index: 2'd0};
			len_q    <= '0;
		end else begin
			if (step) begin
				st_q  <= st_upd;
				len_q <= len_n;
			end
			if (take) begin
				valid_s1 <= 1'b1;
				// a toggle scan types nothing
				rem_s1   <= chord_tog ? '0 : after_sto;
				clr_s1   <= chord_clr;
				tog_s1   <= chord_tog;
			end else if (step) begin
				rem_s1 <= rem_next;
				clr_s1 <= 1'b0;
				tog_s1 <= 1'b0;
				if (finishing) begin
					valid_s1 <= 1'b0;
				end
			end
		end
	end

	// output register, holds while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!char_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q      <= res;
			out_last_q <= (rem_next == '0);
		end
	end

	assign char_valid   = out_valid_q;
	assign char_code    = out_q.char_code;
	assign position     = out_q.position;
	assign replaced     = out_q.replaced;
	assign dropped      = out_q.dropped;
	assign last_of_scan = out_last_q;

endmodule

FILE: hw/rtl/kmte_tap_logic.sv
module kmte_tap_logic #(
	parameter int TEXT_CAPACITY = 32
) (
	input  logic [kmte_pkg::SCAN_W-1:0]           rem,
	input  logic                                  clr,
	input  kmte_pkg::tap_state_t                  st,
	input  logic [$clog2(TEXT_CAPACITY+1)-1:0]    len,
	output kmte_pkg::char_result_t                res,
	output kmte_pkg::tap_state_t                  st_n,
	output logic [$clog2(TEXT_CAPACITY+1)-1:0]    len_n
);
	import kmte_pkg::*;

	localparam int LEN_W = $clog2(TEXT_CAPACITY + 1);

	logic [3:0]       idx;
	logic [LEN_W-1:0] len_e;
	logic [LEN_W-1:0] len_dec;
	logic [LEN_W+4:0] pos_wide;
	logic [LEN_W+4:0] dec_wide;
	logic [3:0]       last_e;
	logic [1:0]       tap_n;
	logic             letter;
	logic             full;

	// lowest pressed button still to type
	always_comb begin
		idx = 4'd0;
		for (int i = SCAN_W - 1; i >= 0; i--) begin
			if (rem[i]) begin
				idx = 4'(i);
			end
		end
	end

	// clear chord takes effect before the first character
	assign len_e   = clr ? '0 : len;
	assign last_e  = clr ? NO_BUTTON : st.last_button;
	assign len_dec = len_e - LEN_W'(1);
	assign pos_wide = {5'd0, len_e};
	assign dec_wide = {5'd0, len_dec};
	assign letter  = st.letter_mode;
	assign full    = (len_e >= LEN_W'(TEXT_CAPACITY));

	always_comb begin
		case (st.tap_index)
			2'd0: tap_n = 2'd1;
			2'd1: tap_n = 2'd2;
			2'd2: tap_n = 2'd0;
			default: tap_n = 2'd1;
		endcase
	end

	always_comb begin
		st_n = st;
		st_n.last_button = last_e;
		len_n = len_e;
		res.char_code = letter ? letter_char(idx, 2'd0) : DIGIT_ONE + 7'(idx);
		res.position  = pos_wide[4:0];
		res.replaced  = 1'b0;
		res.dropped   = 1'b0;
		if (|rem) begin
			if (letter && last_e == idx && len_e != '0) begin
				// same key again: cycle the letter in place
				st_n.tap_index = tap_n;
				res.char_code  = letter_char(idx, tap_n);
				res.position   = dec_wide[4:0];
				res.replaced   = 1'b1;
			end else begin
				if (letter) begin
					st_n.last_button = NO_BUTTON;
				end
				if (full) begin
					res.position = 5'd0;
					res.dropped  = 1'b1;
				end else begin
					if (letter) begin
						st_n.last_button = idx;
						st_n.tap_index   = 2'd0;
					end
					len_n = len_e + LEN_W'(1);
				end
			end
		end
	end

endmodule

FILE: hw/rtl/kmte_checker.sv
`include "keypad_multitap_text_entry_macros.svh"

module kmte_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       scan_valid,
	input logic       scan_stall,
	input logic [8:0] buttons,
	input logic       char_valid,
	input logic       char_stall,
	input logic [6:0] char_code,
	input logic [4:0] position,
	input logic       replaced,
	input logic       dropped,
	input logic       last_of_scan
);

	logic        scan_held;
	logic        char_held;
	logic [14:0] char_word;

	assign scan_held = scan_valid && scan_stall;
	assign char_held = char_valid && char_stall;
	assign char_word = {char_code, position, replaced, dropped, last_of_scan};

	// a stalled scan holds its payload
	`KMTE_ASSERT_NEXT(a_scan_hold, clk, arst_n, scan_held, scan_valid && $stable(buttons))

	// a stalled character holds its payload
	`KMTE_ASSERT_NEXT(a_hold, clk, arst_n, char_held, char_valid && $stable(char_word))

	// characters of one scan follow each other without a gap
	`KMTE_ASSERT_NEXT(a_burst, clk, arst_n, char_valid && !char_stall && !last_of_scan, char_valid)

	// a refused append never overwrites and reports slot zero
	`KMTE_ASSERT_NOW(a_drop, clk, arst_n, char_valid && dropped, !replaced && position == 5'd0)

	// no new scan is taken while a held character is not the last of its scan
	`KMTE_ASSERT_NOW(a_scan, clk, arst_n, char_held && !last_of_scan, scan_stall)

endmodule

bind keypad_multitap_text_entry kmte_checker u_kmte_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.scan_valid  (scan_valid),
	.scan_stall  (scan_stall),
	.buttons     (buttons),
	.char_valid  (char_valid),
	.char_stall  (char_stall),
	.char_code   (char_code),
	.position    (position),
	.replaced    (replaced),
	.dropped     (dropped),
	.last_of_scan(last_of_scan)
);

FILE: tb/tb_keypad_multitap_text_entry.sv
`timescale 1ns / 1ps

module tb_keypad_multitap_text_entry;
	import kmte_pkg::*;

	localparam int TEXT_CAP = 32;
	localparam int RANDOM_SCANS = 300;

	// three letters per key, keys 1 to 9 in order
	localparam string KEY_GROUPS = ".QZABCDEFGHIJKLMNOPRSTUVWXY";

	localparam logic [8:0] CLEAR_CHORD = (9'd1 << CLR_A) | (9'd1 << CLR_B);
	localparam logic [8:0] TOGGLE_CHORD = (9'd1 << TOG_A) | (9'd1 << TOG_B);
	localparam logic [8:0] STORE_CHORD = (9'd1 << STO_A) | (9'd1 << STO_B);

	typedef struct packed {
		logic [6:0] char_code;
		logic [4:0] position;
		logic       replaced;
		logic       dropped;
		logic       last_of_scan;
	} typed_char_t;

	typedef struct {
		logic [8:0] keys;
		bit         drain;
	} scan_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       scan_valid = 1'b0;
	logic       scan_stall;
	logic [8:0] buttons = '0;
	logic       char_valid;
	logic       char_stall = 1'b0;
	logic [6:0] char_code;
	logic [4:0] position;
	logic       replaced;
	logic       dropped;
	logic       last_of_scan;

	// scans waiting to be offered, and characters the block still owes us
	scan_item_t  scan_queue [$];
	typed_char_t typed_chars [$];
	scan_item_t  next_scan;

	// predicted editor state
	logic       letter_mode = 1'b0;
	logic [3:0] last_key = NO_BUTTON;
	logic [1:0] tap = 2'd0;
	int         text_len = 0;

	int scans_sent = 0;
	int mismatches = 0;
	int send_gap_pct;
	int sink_stall_pct;
	int hold_left = 0;
	bit held_once = 1'b0;

	keypad_multitap_text_entry i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.scan_valid   (scan_valid),
		.scan_stall   (scan_stall),
		.buttons      (buttons),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.char_code    (char_code),
		.position     (position),
		.replaced     (replaced),
		.dropped      (dropped),
		.last_of_scan (last_of_scan)
	);

	always #6 clk = ~clk;

	function automatic typed_char_t make_char(input logic [6:0] ch, input logic [4:0] pos,
			input logic repl, input logic drop);
		typed_char_t c;
		c.char_code = ch;
		c.position = pos;
		c.replaced = repl;
		c.dropped = drop;
		c.last_of_scan = 1'b0;
		return c;
	endfunction

	// edit the predicted buffer with one scan and queue the characters it types
	task automatic type_scan(input logic [8:0] keys);
		logic [8:0]  scan;
		logic [6:0]  ch;
		typed_char_t one;
		typed_char_t held;
		bit          have;
		scan = keys;
		have = 1'b0;
		// clear chord wipes the text and forgets the last key, then drops out of the scan
		if ((scan & CLEAR_CHORD) == CLEAR_CHORD) begin
			text_len = 0;
			last_key = NO_BUTTON;
			scan &= ~CLEAR_CHORD;
		end
		// store chord is swallowed
		if ((scan & STORE_CHORD) == STORE_CHORD)
			scan &= ~STORE_CHORD;
		// mode toggle types nothing else in this scan
		if ((scan & TOGGLE_CHORD) == TOGGLE_CHORD) begin
			letter_mode = ~letter_mode;
			return;
		end
		for (int k = 0; k < SCAN_W; k++) begin
			if (scan[k]) begin
				if (letter_mode && last_key == 4'(k) && text_len > 0) begin
					// repeated tap cycles the letter in place
					tap = 2'((int'(tap) + 1) % 3);
					ch = 7'(KEY_GROUPS[3 * k + int'(tap)]);
					one = make_char(ch, 5'(text_len - 1), 1'b1, 1'b0);
				end else begin
					ch = letter_mode ? 7'(KEY_GROUPS[3 * k]) : DIGIT_ONE + 7'(k);
					if (letter_mode)
						last_key = NO_BUTTON;
					if (text_len >= TEXT_CAP) begin
						one = make_char(ch, 5'd0, 1'b0, 1'b1);
					end else begin
						if (letter_mode) begin
							last_key = 4'(k);
							tap = 2'd0;
						end
						one = make_char(ch, 5'(text_len), 1'b0, 1'b0);
						text_len++;
					end
				end
				if (have)
					typed_chars.push_back(held);
				held = one;
				have = 1'b1;
			end
		end
		if (have) begin
			held.last_of_scan = 1'b1;
			typed_chars.push_back(held);
		end
	endtask

	task automatic add_scan(input logic [8:0] keys, input bit drain);
		scan_item_t s;
		s.keys = keys;
		s.drain = drain;
		scan_queue.push_back(s);
	endtask

	// mostly taps and repeated taps on one key, with chords and random noise mixed in
	task automatic add_random_scans(input int count);
		int         pick;
		int         key;
		logic [8:0] keys;
		key = 0;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 33) begin
				key = $urandom_range(SCAN_W - 1);
				keys = 9'd1 << key;
			end else if (pick < 55) begin
				keys = 9'd1 << key;
			end else if (pick < 63) begin
				keys = (9'd1 << $urandom_range(SCAN_W - 1)) | (9'd1 << $urandom_range(SCAN_W - 1));
			end else if (pick < 78) begin
				keys = 9'($urandom);
			end else if (pick < 86) begin
				keys = TOGGLE_CHORD | (9'($urandom) & 9'($urandom));
			end else if (pick < 91) begin
				keys = CLEAR_CHORD | (9'($urandom) & 9'($urandom) & ~TOGGLE_CHORD);
			end else if (pick < 96) begin
				keys = STORE_CHORD | (9'($urandom) & 9'($urandom) & 9'($urandom));
			end else begin
				keys = '0;
			end
			add_scan(keys, (n % 97) == 96);
		end
	endtask

	task automatic report_mismatch(input string what, input typed_char_t want,
			input typed_char_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected char %h pos %0d repl %b drop %b last %b, got char %h pos %0d repl %b drop %b last %b",
				$realtime, what, want.char_code, want.position, want.replaced, want.dropped,
				want.last_of_scan, got.char_code, got.position, got.replaced, got.dropped,
				got.last_of_scan);
	endtask

	// idle rates by phase: sender light then heavy, sink heavy then light, then none
	always_comb begin
		if (scans_sent < 108) begin
			send_gap_pct = 38;
			sink_stall_pct = 57;
		end else if (scans_sent < 216) begin
			send_gap_pct = 57;
			sink_stall_pct = 38;
		end else begin
			send_gap_pct = 0;
			sink_stall_pct = 0;
		end
	end

	// scan driver: predicts on each transfer, then offers the next pending scan
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_valid <= 1'b0;
			buttons <= '0;
		end else begin
			if (scan_valid && !scan_stall) begin
				type_scan(buttons);
				scans_sent <= scans_sent + 1;
			end
			if (!scan_valid || !scan_stall) begin
				// a drain-marked scan waits until every owed character is back
				if (scan_queue.size() > 0 && $urandom_range(99) >= send_gap_pct &&
						!(scan_queue[0].drain && typed_chars.size() != 0)) begin
					next_scan = scan_queue.pop_front();
					scan_valid <= 1'b1;
					buttons <= next_scan.keys;
				end else begin
					scan_valid <= 1'b0;
				end
			end
		end
	end

	// character sink: random stalls, plus one long hold-off while scans keep coming
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_stall <= 1'b0;
		end else if (hold_left > 0) begin
			char_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!held_once && scans_sent >= 250) begin
			held_once <= 1'b1;
			hold_left <= 400;
			char_stall <= 1'b1;
		end else begin
			char_stall <= $urandom_range(99) < sink_stall_pct;
		end
	end

	// checker: every character transfer against the oldest owed character
	always @(posedge clk) begin
		typed_char_t got;
		typed_char_t want;
		if (arst_n && char_valid && !char_stall) begin
			got = {char_code, position, replaced, dropped, last_of_scan};
			if (typed_chars.size() == 0) begin
				report_mismatch("unexpected character", '0, got);
			end else begin
				want = typed_chars.pop_front();
				if (got !== want)
					report_mismatch("wrong character", want, got);
			end
		end
	end

	initial begin
		// number mode basics, then the all-keys scan: clear, swallow, flip to letters
		add_scan(9'h000, 1'b0);
		add_scan(9'h001, 1'b0);
		add_scan(9'h1FF, 1'b0);
		// multi-tap on key 1 wraps around its group
		add_scan(9'h001, 1'b0);
		add_scan(9'h001, 1'b0);
		add_scan(9'h001, 1'b0);
		add_scan(9'h001, 1'b0);
		add_scan(9'h002, 1'b0);
		// clear forgets the last key, so the next tap appends
		add_scan(CLEAR_CHORD, 1'b0);
		add_scan(9'h002, 1'b0);
		add_scan(STORE_CHORD, 1'b0);
		// clear chord with other keys still typing
		add_scan(9'h00F, 1'b1);
		add_scan(TOGGLE_CHORD, 1'b0);
		// fill the buffer with six-key number scans, then overflow
		add_scan(9'h16D, 1'b0);
		add_scan(9'h0DB, 1'b0);
		add_scan(9'h16D, 1'b0);
		add_scan(9'h0DB, 1'b0);
		add_scan(9'h16D, 1'b0);
		add_scan(9'h0DB, 1'b0);
		// letters on a full buffer are refused and forget the key
		add_scan(TOGGLE_CHORD, 1'b0);
		add_scan(9'h008, 1'b0);
		add_scan(9'h008, 1'b0);
		add_scan(CLEAR_CHORD | STORE_CHORD, 1'b0);
		add_scan(9'h1FF, 1'b1);
		add_random_scans(RANDOM_SCANS);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (scan_queue.size() != 0 || scan_valid)
			@(posedge clk);
		while (typed_chars.size() != 0)
			@(posedge clk);
		// let any late extra character show up
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2_400_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
